// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hwc_pkg.sv =====
package hwc_pkg;

   localparam int COUNT_BITS = 24;
   localparam int OUT_BITS   = 24;
   localparam int NUM_BINS   = 256;
   localparam int BIN_BITS   = $clog2(NUM_BINS);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(NUM_BINS - 1);

   localparam logic CMD_COUNT = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load;      // capture item, start bin read
      logic do_count;  // write incremented bin
      logic do_read;   // emit readout, advance pointer
   } hwc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_read;   // held item is a readout
      logic out_busy;  // output register full and not draining
   } hwc_status_type;

endpackage

// ===== sv/hwc_ctrl.sv =====
module hwc_ctrl
   import hwc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  hwc_status_type status,
   output hwc_cmd_type    cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.load     = 1'b0;
      cmd.do_count = 1'b0;
      cmd.do_read  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!status.is_read) begin
               cmd.do_count = 1'b1;
               state_in     = S_IDLE;
            end else if (!status.out_busy) begin
               cmd.do_read = 1'b1;
               state_in    = S_IDLE;
            end
            // otherwise hold until the result register frees up
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/hwc_datapath.sv =====
module hwc_datapath
   import hwc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  hwc_cmd_type           cmd,
   output hwc_status_type        status,
   input  logic                  req_command,
   input  logic [BIN_BITS-1:0]   req_pixel,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [BIN_BITS-1:0]   rsp_bin_index,
   output logic [OUT_BITS-1:0]   rsp_bin_count,
   output logic [OUT_BITS-1:0]   rsp_cumulative,
   output logic                  rsp_last
);

   logic [COUNT_BITS-1:0] mem [NUM_BINS];

   logic                  is_read_ff;
   logic [BIN_BITS-1:0]   addr_ff;
   logic [BIN_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_vld_ff;
   logic [NUM_BINS-1:0]   valid_ff;
   logic [NUM_BINS-1:0]   valid_in;
   logic [BIN_BITS-1:0]   ptr_ff;
   logic [BIN_BITS-1:0]   ptr_in;
   logic [COUNT_BITS-1:0] sum_ff;
   logic [COUNT_BITS-1:0] sum_in;
   logic [COUNT_BITS-1:0] bin_val;
   logic [COUNT_BITS-1:0] bin_inc;
   logic [COUNT_BITS:0]   sum_wide;
   logic [COUNT_BITS-1:0] cum;
   logic                  is_last;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [BIN_BITS-1:0]   out_index_ff;
   logic [OUT_BITS-1:0]   out_count_ff;
   logic [OUT_BITS-1:0]   out_cum_ff;
   logic                  out_last_ff;

   assign rd_addr  = (req_command == CMD_READ) ? ptr_ff : req_pixel;

   // An entry not written since the last clear reads as zero
   assign bin_val  = rd_vld_ff ? rd_data_ff : '0;
   assign bin_inc  = (bin_val == COUNT_MAX) ? bin_val : bin_val + 1'b1;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, bin_val};
   assign cum      = sum_wide[COUNT_BITS] ? COUNT_MAX : sum_wide[COUNT_BITS-1:0];
   assign is_last  = (ptr_ff == LAST_BIN);

   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      sum_in   = sum_ff;
      if (cmd.do_count) begin
         valid_in[addr_ff] = 1'b1;
      end
      if (cmd.do_read) begin
         if (is_last) begin
            valid_in = '0;
            ptr_in   = '0;
            sum_in   = '0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
            sum_in = cum;
         end
      end
   end

   always_comb begin
      if (cmd.do_read) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_count) begin
         mem[addr_ff] <= bin_inc;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= req_command;
         addr_ff    <= rd_addr;
         rd_vld_ff  <= valid_ff[rd_addr];
      end
      if (cmd.do_read) begin
         out_index_ff <= ptr_ff;
         out_count_ff <= OUT_BITS'(bin_val);
         out_cum_ff   <= OUT_BITS'(cum);
         out_last_ff  <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.is_read  = is_read_ff;
   assign status.out_busy = out_valid_ff && !rsp_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_bin_index  = out_index_ff;
   assign rsp_bin_count  = out_count_ff;
   assign rsp_cumulative = out_cum_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== sv/histogram_with_cumulative.sv =====
// 256-bin grey-level histogram with cumulative readout.
// Request channel (req_): tuser is the command, 0 counts the pixel in tdata[7:0]
// into its bin, 1 reads out the next bin. Only readouts produce a transfer on
// the response channel (rsp_), which carries the bin index, its count and the
// running cumulative count; tlast marks bin 255.
// Each request first reads its bin from the store, then updates it or
// forms the result; req_tready stays low while a request is in flight.
// A response is written to an output register when its readout completes
// and sits there; count requests keep flowing while it waits.
// A readout that finds the output register still full and not being taken
// holds in place until rsp_tready frees it, and no new request is taken
// meanwhile.
// Reset clears the per-bin valid flags, so the whole store reads as zero at
// once; no clearing pass is needed. The same flags clear after bin 255 is
// read out, together with the readout pointer and the running sum.
// Counts and sums saturate at the counter maximum.
`include "assert_macros.svh"

module histogram_with_cumulative
   import hwc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] bin_index, [31:8] bin_count,
                                    // [55:32] cumulative_count
   output logic        rsp_tlast    // last_bin
);

   hwc_cmd_type           cmd;
   hwc_status_type        status;
   logic [BIN_BITS-1:0]   bin_index;
   logic [OUT_BITS-1:0]   bin_count;
   logic [OUT_BITS-1:0]   cum_count;

   hwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   hwc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_command    (req_tuser),
      .req_pixel      (req_tdata[BIN_BITS-1:0]),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_bin_index  (bin_index),
      .rsp_bin_count  (bin_count),
      .rsp_cumulative (cum_count),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {cum_count, bin_count, bin_index};

   `ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready,
      "request taken while previous one in flight")

   `ASSERT_SAME(a_last_index, clock, reset, rsp_tvalid && rsp_tlast, bin_index == LAST_BIN,
      "last flag on a bin other than the final one")

   `ASSERT_SAME(a_cum_ge_count, clock, reset, rsp_tvalid, cum_count >= bin_count,
      "cumulative count below bin count")

endmodule
